### hw/rtl/cssc_pkg.sv
package cssc_pkg;

    localparam int BYTE_W   = 8;
    localparam int CLASS_W  = 3;
    localparam int KW_ROWS  = 44;
    localparam int KW_CHARS = 8;
    localparam int KW_W     = BYTE_W * KW_CHARS;

    localparam int DEF_MAX_KEYWORD_LEN = 8;
    localparam int DEF_KEYWORD_COUNT   = 44;
    localparam int DEF_CMD_DEPTH       = 4;

    localparam logic [CLASS_W-1:0] CLS_PLAIN   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_KEYWORD = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_COMMENT = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_STRING  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_NUMBER  = 3'd4;

    // how the back end tags a held identifier run
    localparam logic [1:0] WMODE_DEFAULT = 2'd0;
    localparam logic [1:0] WMODE_KEYWORD = 2'd1;
    localparam logic [1:0] WMODE_PLAIN   = 2'd2;

    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2a;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5f;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0a;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_out;
        logic [CLASS_W-1:0] byte_class;
        logic               run_last;
    } out_item_t;

    // fixed part of one queued command: held slash, run tagging, trailing byte
    typedef struct packed {
        logic               head_valid;
        logic [CLASS_W-1:0] head_class;
        logic [1:0]         word_mode;
        logic               tail_valid;
        logic [BYTE_W-1:0]  tail_byte;
        logic [CLASS_W-1:0] tail_class;
    } cmd_ctl_t;

    function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident(input logic [BYTE_W-1:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic [CLASS_W-1:0] default_class(input logic [BYTE_W-1:0] c,
                                                        input logic [BYTE_W-1:0] prev);
        return (is_digit(c) && !is_alpha(prev)) ? CLS_NUMBER : CLS_PLAIN;
    endfunction

    // keyword text, right-justified, first character in the highest used byte
    function automatic logic [KW_W-1:0] kw_entry(input int row);
        logic [KW_W-1:0] e;
        case (row)
            0:  e = KW_W'("auto");
            1:  e = KW_W'("break");
            2:  e = KW_W'("case");
            3:  e = KW_W'("char");
            4:  e = KW_W'("const");
            5:  e = KW_W'("continue");
            6:  e = KW_W'("default");
            7:  e = KW_W'("do");
            8:  e = KW_W'("double");
            9:  e = KW_W'("else");
            10: e = KW_W'("enum");
            11: e = KW_W'("extern");
            12: e = KW_W'("float");
            13: e = KW_W'("for");
            14: e = KW_W'("goto");
            15: e = KW_W'("if");
            16: e = KW_W'("int");
            17: e = KW_W'("long");
            18: e = KW_W'("register");
            19: e = KW_W'("return");
            20: e = KW_W'("short");
            21: e = KW_W'("signed");
            22: e = KW_W'("sizeof");
            23: e = KW_W'("static");
            24: e = KW_W'("struct");
            25: e = KW_W'("switch");
            26: e = KW_W'("typedef");
            27: e = KW_W'("union");
            28: e = KW_W'("unsigned");
            29: e = KW_W'("void");
            30: e = KW_W'("volatile");
            31: e = KW_W'("while");
            32: e = KW_W'("uint8_t");
            33: e = KW_W'({"uint16", "_t"});
            34: e = KW_W'({"uint32", "_t"});
            35: e = KW_W'({"uint64", "_t"});
            36: e = KW_W'("int8_t");
            37: e = KW_W'("int16_t");
            38: e = KW_W'("int32_t");
            39: e = KW_W'("int64_t");
            40: e = KW_W'("size_t");
            41: e = KW_W'("NULL");
            42: e = KW_W'("true");
            43: e = KW_W'("false");
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic int kw_len(input int row);
        logic [KW_W-1:0] e;
        int n;
        e = kw_entry(row);
        n = 0;
        for (int i = 0; i < KW_CHARS; i++) begin
            if (e[BYTE_W*i +: BYTE_W] != '0) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input int row, input int pos);
        logic [KW_W-1:0] e;
        int n;
        e = kw_entry(row);
        n = kw_len(row);
        if (pos < n) begin
            return e[BYTE_W*(n-1-pos) +: BYTE_W];
        end
        return '0;
    endfunction

endpackage

### hw/rtl/cssc_front.sv
module cssc_front
    import cssc_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
    parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
    localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  in_item_t                      s_data,
    input  logic                          cmd_ready,
    output logic                          cmd_valid,
    output cmd_ctl_t                      cmd_ctl,
    output logic [LEN_W-1:0]              cmd_len,
    output logic [BYTE_W*MAX_KEYWORD_LEN-1:0] cmd_word
);

    localparam int IDX_W   = $clog2(MAX_KEYWORD_LEN);
    localparam int KW_USED = (KEYWORD_COUNT < KW_ROWS) ? KEYWORD_COUNT : KW_ROWS;

    typedef enum logic [3:0] {
        LX_NORMAL = 4'b0001,
        LX_LINE   = 4'b0010,
        LX_BLOCK  = 4'b0100,
        LX_STRING = 4'b1000
    } lex_mode_t;

    logic              enable_reg, enable_next;
    lex_mode_t         mode_reg, mode_next, mode_cur;
    logic [BYTE_W-1:0] quote_reg, quote_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic              held_reg, held_next;
    logic [LEN_W-1:0]  len_reg, len_next, post_len;
    logic              over_reg, over_next;
    logic [KW_USED-1:0] cand_reg, cand_next, hit_start, hit_cont;
    logic [BYTE_W-1:0] word_store_reg [MAX_KEYWORD_LEN];
    logic [BYTE_W-1:0] word_next [MAX_KEYWORD_LEN];

    logic              accept, active, st_wr, st_start;
    logic [IDX_W-1:0]  st_idx;
    logic              flush_pre, pre_default, pre_plain, kw_pre, kw_post;
    logic [BYTE_W-1:0] c;
    logic              fin;
    cmd_ctl_t          ctl_base;

    assign c       = s_data.text_byte;
    assign fin     = s_data.end_of_text;
    assign s_ready = cmd_ready;
    assign accept  = s_valid & s_ready;
    assign active  = (len_reg != '0) || over_reg;
    assign st_idx  = st_start ? '0 : len_reg[IDX_W-1:0];

    // candidate keywords still matching after this byte
    always_comb begin
        for (int k = 0; k < KW_USED; k++) begin
            hit_start[k] = 1'b0;
            hit_cont[k]  = 1'b0;
            for (int p = 0; p < KW_CHARS; p++) begin
                if (kw_char(k, p) == c) begin
                    if (p == 0) begin
                        hit_start[k] = 1'b1;
                    end
                    if (int'(len_reg) == p) begin
                        hit_cont[k] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        enable_next = cfg_wr_en ? cfg_wr_data : enable_reg;
        mode_next   = mode_reg;
        mode_cur    = mode_reg;
        quote_next  = quote_reg;
        prev_next   = prev_reg;
        held_next   = held_reg;
        len_next    = len_reg;
        over_next   = over_reg;
        st_wr       = 1'b0;
        st_start    = 1'b0;
        flush_pre   = 1'b0;
        pre_default = 1'b0;
        pre_plain   = 1'b0;
        post_len    = '0;
        ctl_base    = '0;
        if (accept) begin
            if (!enable_reg) begin
                ctl_base.head_valid = held_reg;
                ctl_base.head_class = CLS_PLAIN;
                held_next = 1'b0;
                if (len_reg != '0) begin
                    flush_pre = 1'b1;
                    pre_plain = 1'b1;
                end
                len_next   = '0;
                over_next  = 1'b0;
                mode_next  = LX_NORMAL;
                quote_next = '0;
                ctl_base.tail_valid = 1'b1;
                ctl_base.tail_byte  = c;
                ctl_base.tail_class = CLS_PLAIN;
            end else begin
                // resolve the held slash with this byte as lookahead
                if (held_reg) begin
                    ctl_base.head_valid = 1'b1;
                    ctl_base.head_class = CLS_PLAIN;
                    if (c == CH_SLASH) begin
                        mode_cur = LX_LINE;
                        ctl_base.head_class = CLS_COMMENT;
                    end else if (c == CH_STAR) begin
                        mode_cur = LX_BLOCK;
                        ctl_base.head_class = CLS_COMMENT;
                    end
                    held_next = 1'b0;
                end
                mode_next = mode_cur;
                ctl_base.tail_byte = c;
                if (c == CH_NL) begin
                    flush_pre = (len_reg != '0);
                    len_next  = '0;
                    over_next = 1'b0;
                    if (mode_cur == LX_LINE) begin
                        mode_next = LX_NORMAL;
                    end
                    ctl_base.tail_valid = 1'b1;
                    ctl_base.tail_class = CLS_PLAIN;
                end else begin
                    case (mode_cur)
                        LX_LINE: begin
                            ctl_base.tail_valid = 1'b1;
                            ctl_base.tail_class = CLS_COMMENT;
                        end
                        LX_BLOCK: begin
                            ctl_base.tail_valid = 1'b1;
                            if (prev_reg == CH_STAR && c == CH_SLASH) begin
                                mode_next = LX_NORMAL;
                                ctl_base.tail_class = CLS_PLAIN;
                            end else begin
                                ctl_base.tail_class = CLS_COMMENT;
                            end
                        end
                        LX_STRING: begin
                            if (c == quote_reg && prev_reg != CH_BSLASH) begin
                                mode_next  = LX_NORMAL;
                                quote_next = '0;
                            end
                            ctl_base.tail_valid = 1'b1;
                            ctl_base.tail_class = CLS_STRING;
                        end
                        LX_NORMAL: begin
                            if (active && is_ident(c)) begin
                                if (over_reg) begin
                                    ctl_base.tail_valid = 1'b1;
                                    ctl_base.tail_class = default_class(c, prev_reg);
                                end else if (len_reg < LEN_W'(MAX_KEYWORD_LEN)) begin
                                    st_wr    = 1'b1;
                                    len_next = LEN_W'(len_reg + 1'b1);
                                end else begin
                                    // run too long for a keyword: drain it untagged
                                    flush_pre   = 1'b1;
                                    pre_default = 1'b1;
                                    ctl_base.tail_valid = 1'b1;
                                    ctl_base.tail_class = default_class(c, prev_reg);
                                    len_next  = '0;
                                    over_next = 1'b1;
                                end
                            end else begin
                                if (active) begin
                                    flush_pre = (len_reg != '0);
                                    len_next  = '0;
                                    over_next = 1'b0;
                                end
                                if (is_alpha(c) && !is_ident(prev_reg)) begin
                                    st_wr    = 1'b1;
                                    st_start = 1'b1;
                                    len_next = LEN_W'(1);
                                end else if (c == CH_SLASH && !fin) begin
                                    held_next = 1'b1;
                                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                                    mode_next  = LX_STRING;
                                    quote_next = c;
                                    ctl_base.tail_valid = 1'b1;
                                    ctl_base.tail_class = CLS_STRING;
                                end else begin
                                    ctl_base.tail_valid = 1'b1;
                                    ctl_base.tail_class = default_class(c, prev_reg);
                                end
                            end
                        end
                        default: begin
                            mode_next = LX_NORMAL;
                        end
                    endcase
                end
            end
            prev_next = c;
            // last byte of text: drain the run and start over
            if (fin) begin
                post_len   = len_next;
                len_next   = '0;
                over_next  = 1'b0;
                mode_next  = LX_NORMAL;
                quote_next = '0;
                prev_next  = '0;
                held_next  = 1'b0;
            end
        end
    end

    assign cand_next = !st_wr ? cand_reg : (st_start ? hit_start : (cand_reg & hit_cont));

    always_comb begin
        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
            word_next[i] = (st_wr && st_idx == IDX_W'(i)) ? c : word_store_reg[i];
            cmd_word[BYTE_W*i +: BYTE_W] = word_next[i];
        end
    end

    always_comb begin
        kw_pre  = 1'b0;
        kw_post = 1'b0;
        for (int k = 0; k < KW_USED; k++) begin
            if (cand_reg[k] && kw_len(k) == int'(len_reg)) begin
                kw_pre = 1'b1;
            end
            if (cand_next[k] && kw_len(k) == int'(post_len)) begin
                kw_post = 1'b1;
            end
        end
        cmd_ctl = ctl_base;
        if (flush_pre) begin
            cmd_len = len_reg;
            if (pre_plain) begin
                cmd_ctl.word_mode = WMODE_PLAIN;
            end else if (!pre_default && kw_pre) begin
                cmd_ctl.word_mode = WMODE_KEYWORD;
            end else begin
                cmd_ctl.word_mode = WMODE_DEFAULT;
            end
        end else begin
            cmd_len = post_len;
            cmd_ctl.word_mode = kw_post ? WMODE_KEYWORD : WMODE_DEFAULT;
        end
    end

    // steps that only hold bytes push nothing
    assign cmd_valid = accept && (ctl_base.head_valid || ctl_base.tail_valid || cmd_len != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            mode_reg   <= LX_NORMAL;
            quote_reg  <= '0;
            prev_reg   <= '0;
            held_reg   <= 1'b0;
            len_reg    <= '0;
            over_reg   <= 1'b0;
        end else begin
            enable_reg <= enable_next;
            mode_reg   <= mode_next;
            quote_reg  <= quote_next;
            prev_reg   <= prev_next;
            held_reg   <= held_next;
            len_reg    <= len_next;
            over_reg   <= over_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if (st_wr) begin
            word_store_reg[st_idx] <= c;
        end
    end

endmodule

### hw/rtl/cssc_cmd_fifo.sv
module cssc_cmd_fifo
    import cssc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_CMD_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/cssc_back.sv
module cssc_back
    import cssc_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
    localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    input  cmd_ctl_t                          cmd_ctl,
    input  logic [LEN_W-1:0]                  cmd_len,
    input  logic [BYTE_W*MAX_KEYWORD_LEN-1:0] cmd_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output out_item_t                         m_data
);

    localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);

    typedef enum logic [1:0] {
        PH_HEAD = 2'b01,
        PH_BODY = 2'b10
    } phase_t;

    phase_t            ph_reg, ph_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              advance, go, sel_head, word_left, last;
    logic [BYTE_W-1:0] word_byte, word_prev;
    out_item_t         cur;

    assign advance   = !m_valid_reg || m_ready;
    assign go        = advance && cmd_valid;
    assign sel_head  = (ph_reg == PH_HEAD) && cmd_ctl.head_valid;
    assign word_left = idx_reg < cmd_len;
    assign word_byte = cmd_word[{idx_reg[IDX_W-1:0], 3'b000} +: BYTE_W];
    assign word_prev = (idx_reg == '0) ? '0 : prev_reg;

    // pick the next word of the command: held slash, then the run, then the byte
    always_comb begin
        cur = '0;
        if (sel_head) begin
            cur.byte_out   = CH_SLASH;
            cur.byte_class = cmd_ctl.head_class;
            last = (cmd_len == '0) && !cmd_ctl.tail_valid;
        end else if (word_left) begin
            cur.byte_out = word_byte;
            case (cmd_ctl.word_mode)
                WMODE_KEYWORD: cur.byte_class = CLS_KEYWORD;
                WMODE_PLAIN:   cur.byte_class = CLS_PLAIN;
                default:       cur.byte_class = default_class(word_byte, word_prev);
            endcase
            last = (LEN_W'(idx_reg + 1'b1) == cmd_len) && !cmd_ctl.tail_valid;
        end else begin
            cur.byte_out   = cmd_ctl.tail_byte;
            cur.byte_class = cmd_ctl.tail_class;
            last = 1'b1;
        end
        cur.run_last = last;
    end

    assign cmd_pop = go && last;

    always_comb begin
        ph_next      = ph_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (go) begin
            m_valid_next = 1'b1;
            m_data_next  = cur;
            if (last) begin
                ph_next  = PH_HEAD;
                idx_next = '0;
            end else if (sel_head) begin
                ph_next = PH_BODY;
            end else begin
                ph_next   = PH_BODY;
                idx_next  = LEN_W'(idx_reg + 1'b1);
                prev_next = word_byte;
            end
        end else if (advance) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= PH_HEAD;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ph_reg      <= ph_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg   <= prev_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/c_source_syntax_classifier_top.sv
// A byte tagged at once goes through the command queue and the output register to m_data.
// Throughput: one input word per cycle while the command queue has room; the output
// register drains one result word per cycle while m_ready is high, and an identifier
// run of up to MAX_KEYWORD_LEN bytes leaves in one burst when it ends.
// Reset: aresetn (synchronous, active low) clears the lexer, queue and output valid;
// highlighting comes up disabled and no clearing pass runs.
module c_source_syntax_classifier_top
    import cssc_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
    parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
    parameter int CMD_DEPTH       = DEF_CMD_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int LEN_W  = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int WORD_W = BYTE_W * MAX_KEYWORD_LEN;
    localparam int CTL_W  = $bits(cmd_ctl_t);
    localparam int CMD_W  = CTL_W + LEN_W + WORD_W;

    logic              push_valid, push_ready, pop_valid, pop_ready;
    cmd_ctl_t          push_ctl, pop_ctl;
    logic [LEN_W-1:0]  push_len, pop_len;
    logic [WORD_W-1:0] push_word, pop_word;
    logic [CMD_W-1:0]  push_data, pop_data;

    cssc_front #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .KEYWORD_COUNT   (KEYWORD_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cmd_ready   (push_ready),
        .cmd_valid   (push_valid),
        .cmd_ctl     (push_ctl),
        .cmd_len     (push_len),
        .cmd_word    (push_word)
    );

    assign push_data = {push_ctl, push_len, push_word};

    cssc_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_ctl  = cmd_ctl_t'(pop_data[CMD_W-1 -: CTL_W]);
    assign pop_len  = pop_data[WORD_W +: LEN_W];
    assign pop_word = pop_data[WORD_W-1:0];

    cssc_back #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop_ready),
        .cmd_ctl   (pop_ctl),
        .cmd_len   (pop_len),
        .cmd_word  (pop_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
